[rtl/core/rsa_modular_exponentiation_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define RME_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RME_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define RME_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define RME_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/rme_pkg.sv]
// Shared types, constants and the radix-2 modular step for the exponentiation core.
// No dependencies; used by rme_modmul and rsa_modular_exponentiation.
package rme_pkg;

    // Operand width and digit size of the serial multiplier.
    localparam int VALUE_BITS = 12;
    localparam int DIGIT_BITS = 2;
    localparam int DIGITS     = VALUE_BITS / DIGIT_BITS;
    localparam int CNT_W      = $clog2(DIGITS);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int CFG_IDX_W  = 2;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [VALUE_BITS:0]   t_modulus;
    typedef logic [VALUE_BITS+1:0] t_wide;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_EXPONENT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MODULUS  = t_cfg_idx'(1);

    // Reset values of the configuration registers.
    localparam t_value EXP_RESET = t_value'(1);
    localparam t_value MOD_RESET = '1;
    localparam t_value VALUE_ONE = t_value'(1);

    // Request to the serial multiplier: product = mcand * mplier mod modulus.
    typedef struct packed {
        logic     start;
        t_value   mcand;
        t_value   mplier;
        t_modulus modulus;
    } t_mul_req;

    // Response from the serial multiplier.
    typedef struct packed {
        logic   done;
        t_value product;
    } t_mul_rsp;

    // One multiplier bit: r' = (2r + b*a) mod m, with r < m and a <= m.
    function automatic t_value f_bit_step(t_value r, t_value a, logic b, t_modulus m);
        t_wide d;
        t_wide s;
        t_wide mw;
        mw = {1'b0, m};
        d  = {1'b0, r, 1'b0};
        if (d >= mw) begin
            d = d - mw;
        end
        s = d + (b ? {2'b00, a} : '0);
        if (s >= mw) begin
            s = s - mw;
        end
        return s[VALUE_BITS-1:0];
    endfunction

endpackage

[rtl/core/rme_modmul.sv]
// Digit-serial modular multiplier, DIGIT_BITS multiplier bits per cycle, MSB first.
// Depends on rme_pkg for widths, request and response structs and the bit step.
module rme_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rme_pkg::t_mul_req i_req,
    output rme_pkg::t_mul_rsp o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [rme_pkg::CNT_W-1:0]  r_cnt;
    rme_pkg::t_value            r_mplier;
    rme_pkg::t_value            r_mcand;
    rme_pkg::t_modulus          r_mod;
    rme_pkg::t_value            r_acc;
    rme_pkg::t_value            n_acc;

    // Two interleaved double-and-add steps for the top digit of the multiplier.
    always_comb begin
        rme_pkg::t_value tmp;
        tmp = r_acc;
        for (int i = 0; i < rme_pkg::DIGIT_BITS; i++) begin
            tmp = rme_pkg::f_bit_step(tmp, r_mcand, r_mplier[rme_pkg::VALUE_BITS-1-i], r_mod);
        end
        n_acc = tmp;
    end

    // Control: a start loads the operands, then one digit is consumed per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rme_pkg::CNT_W'(rme_pkg::DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: multiplier shift register and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mplier <= i_req.mplier;
            r_mcand  <= i_req.mcand;
            r_mod    <= i_req.modulus;
            r_acc    <= '0;
        end else if (r_busy) begin
            r_mplier <= r_mplier << rme_pkg::DIGIT_BITS;
            r_acc    <= n_acc;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

[rtl/core/rsa_modular_exponentiation.sv]
// Channel   | Direction | Signals                                      | Transaction
// command   | in        | start, busy, i_message_value                 | start & !busy
// result    | out       | o_done, o_transformed_value                  | o_done, one cycle
// config    | in        | i_cfg_valid, o_cfg_ready, i_cfg_index/_data  | valid & ready
//
// Unless the exponent is zero, each value is first reduced, then handled by
// left-to-right square-and-multiply. Every modular product is formed in the shared
// serial multiplier, and each exponent bit also passes through the bit-select state.
// A zero exponent gives the result 1 without the multiplier.
// Reset (synchronous, active low) restores exponent 1 and modulus 4095.
// Results cannot be stalled; busy drops in the cycle the result strobe is shown.
`include "rsa_modular_exponentiation_defines.svh"

module rsa_modular_exponentiation (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rme_pkg::t_value           i_message_value,
    output logic                      o_done,
    output rme_pkg::t_value           o_transformed_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  rme_pkg::t_cfg_idx         i_cfg_index,
    input  rme_pkg::t_value           i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_BIT    = 3'd2;
    localparam logic [2:0] S_SQR    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    rme_pkg::t_value           r_exponent;
    rme_pkg::t_value           r_modulus;
    rme_pkg::t_value           r_base;
    rme_pkg::t_value           n_base;
    rme_pkg::t_value           r_acc;
    rme_pkg::t_value           n_acc;
    logic [rme_pkg::BIT_W-1:0] r_bit;
    logic [rme_pkg::BIT_W-1:0] n_bit;
    logic                      r_started;
    logic                      n_started;
    rme_pkg::t_value           r_result;
    rme_pkg::t_value           n_result;
    logic                      r_done;
    logic                      n_done;
    logic                      advance;
    logic                      exp_bit;
    rme_pkg::t_modulus         mod_eff;
    rme_pkg::t_mul_req         mul_req;
    rme_pkg::t_mul_rsp         mul_rsp;

    // A modulus of zero stands for 2^VALUE_BITS.
    assign mod_eff = {(r_modulus == '0), r_modulus};
    assign exp_bit = r_exponent[r_bit];

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= rme_pkg::EXP_RESET;
            r_modulus  <= rme_pkg::MOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rme_pkg::CFG_EXPONENT: r_exponent <= i_cfg_data;
                rme_pkg::CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared serial modular multiplier.
    rme_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Square-and-multiply sequencer.
    always_comb begin
        n_state         = r_state;
        n_base          = r_base;
        n_acc           = r_acc;
        n_bit           = r_bit;
        n_started       = r_started;
        n_result        = r_result;
        n_done          = 1'b0;
        advance         = 1'b0;
        mul_req.start   = 1'b0;
        mul_req.mcand   = r_base;
        mul_req.mplier  = r_acc;
        mul_req.modulus = mod_eff;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_exponent == '0) begin
                        n_result = rme_pkg::VALUE_ONE;
                        n_done   = 1'b1;
                    end else begin
                        // Reduce the message: message * 1 mod modulus.
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = rme_pkg::VALUE_ONE;
                        mul_req.mplier = i_message_value;
                        n_state        = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_rsp.done) begin
                    n_base    = mul_rsp.product;
                    n_acc     = rme_pkg::VALUE_ONE;
                    n_bit     = rme_pkg::BIT_W'(rme_pkg::VALUE_BITS - 1);
                    n_started = 1'b0;
                    n_state   = S_BIT;
                end
            end
            S_BIT: begin
                if (r_started) begin
                    mul_req.start = 1'b1;
                    mul_req.mcand = r_acc;
                    n_state       = S_SQR;
                end else if (exp_bit) begin
                    mul_req.start = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    advance = 1'b1;
                end
            end
            S_SQR: begin
                if (mul_rsp.done) begin
                    n_acc = mul_rsp.product;
                    if (exp_bit) begin
                        mul_req.start  = 1'b1;
                        mul_req.mplier = mul_rsp.product;
                        n_state        = S_MUL;
                    end else begin
                        advance = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    n_acc     = mul_rsp.product;
                    n_started = 1'b1;
                    advance   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Move to the next exponent bit, or finish after the last one.
        if (advance) begin
            if (r_bit == '0) begin
                n_result = n_acc;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_bit   = r_bit - 1'b1;
                n_state = S_BIT;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_started <= n_started;
        end
    end

    // Working values and result.
    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_acc    <= n_acc;
        r_bit    <= n_bit;
        r_result <= n_result;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_transformed_value = r_result;

    // The result strobe is only shown once the sequencer is back in idle.
    `RME_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // An accepted command either starts work or answers in the next cycle.
    `RME_ASSERT_NEXT(a_start_progress, i_clk, i_rst_n, start && !busy, busy || o_done)
    // The multiplier only answers while the sequencer waits for a product.
    `RME_ASSERT_IMPLY(a_mul_owner, i_clk, i_rst_n, mul_rsp.done,
        r_state == S_REDUCE || r_state == S_SQR || r_state == S_MUL)
    // A result from a nonzero exponent is fully reduced.
    `RME_ASSERT_IMPLY(a_reduced, i_clk, i_rst_n,
        o_done && (r_exponent != '0) && (r_modulus != '0), o_transformed_value < r_modulus)

endmodule
